// ===== rtl/core/mkcr_pkg.sv =====
// Shared types and constants for the matrix key change reporter.
`timescale 1ns / 1ps

package mkcr_pkg;

    // Matrix geometry
    localparam int SIDE        = 8;
    localparam int SIDE_W      = 3;
    localparam int MATRIX_KEYS = 64;
    localparam int KEY_W       = 6;

    // Result field widths
    localparam int KEY_CODE_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int IN_TDATA_W  = 192;

    // Configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Item kinds on tuser
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // One change event on its way to the output
    typedef struct packed {
        logic              pressed;
        logic [SIDE_W-1:0] row;
        logic [SIDE_W-1:0] col;
        logic              last;
    } t_evt;

endpackage

// ===== rtl/core/mkcr_vmem.sv =====
// Synchronous single-port-read memory with per-entry valid bits cleared at reset.
`timescale 1ns / 1ps

module mkcr_vmem #(
    parameter int W = 8,
    parameter int A = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_rd_en,
    input  logic [A-1:0] i_rd_addr,
    output logic [W-1:0] o_rd_data,
    input  logic         i_wr_en,
    input  logic [A-1:0] i_wr_addr,
    input  logic [W-1:0] i_wr_data
);

    localparam int DEPTH = 2 ** A;

    logic [W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [W-1:0]     r_q;
    logic             r_q_vld;

    // Storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // Valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

// ===== rtl/core/mkcr_evt_out.sv =====
// Event output stage: pending slot waiting for keycode data, then output register.
`timescale 1ns / 1ps

module mkcr_evt_out
    import mkcr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_issue_v,
    input  t_evt                   i_issue,
    input  logic [KEY_CODE_W-1:0]  i_code,
    output logic                   o_can_issue,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // key_code[23:0], pressed[24], row_index[27:25], col_index[30:28], zero[31]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic                   r_pend_v;
    t_evt                   r_pend;
    logic                   r_out_v;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_last;
    logic                   out_free;
    logic                   pend_move;

    assign out_free    = !r_out_v || m_axis_tready;
    assign pend_move   = r_pend_v && out_free;
    assign o_can_issue = !r_pend_v || pend_move;

    // Pending slot: the keycode read is in flight for this event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (i_issue_v) begin
            r_pend_v <= 1'b1;
        end else if (pend_move) begin
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue_v) begin
            r_pend <= i_issue;
        end
    end

    // Output register: hold the beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (pend_move) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_out_data <= {1'b0, r_pend.col, r_pend.row, r_pend.pressed, i_code};
            r_out_last <= r_pend.last;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // Checks
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_issue_v |-> o_can_issue)
        else $error("event issued while pending slot busy");

    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && !out_free) |=> (r_pend_v && $stable(r_pend)))
        else $error("pending event lost while output stalled");

endmodule

// ===== rtl/core/matrix_key_change_reporter_unit.sv =====
// Top level of the matrix key change reporter: sequencer, key map and keycode table.
`timescale 1ns / 1ps

// Input beats (s_axis) carry either a keycode load (tuser = 1) or a scan
// snapshot (tuser = 0). A load writes one keycode table entry and produces
// no output. A scan builds the new 8x8 pressed map and compares it with
// the stored map column by column, then walks the positions up to the last
// changed key and emits one output beat (m_axis) per changed key inside the
// configured rows and columns, column-major, with tlast on the final one.
// A scan with no change emits nothing.
// A scan first makes a compare pass over the key map memory, one column per
// cycle, then steps through the positions, pausing while the output stage
// is full, and closes the walk; tready stays low throughout. Each output
// beat takes its keycode from the registered table read as its event moves
// from the pending slot into the output register.
// tready is high only between items.
// A stalled receiver stops the walk once one event waits in the output
// register and one in the pending slot; nothing is dropped.
// Reset clears the key map and keycode table through valid bits at once
// and sets both row and column counts to 8. Configuration writes are
// taken in any cycle but belong between items.
module matrix_key_change_reporter_unit
    import mkcr_pkg::*;
#(
    parameter int KEYCODE_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [3:0]             i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // scan_status_word[31:0], multi_word_0[63:32], multi_word_1[95:64],
    // multi_word_2[127:96], multi_word_3[159:128], map_entry[191:160]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // key_code[23:0], pressed[24], row_index[27:25], col_index[30:28], zero[31]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_COLS = 2'd1;
    localparam logic [1:0] S_EVT  = 2'd2;

    // Configuration
    logic [3:0] r_rows;
    logic [3:0] r_cols;
    logic [3:0] nrows;
    logic [3:0] ncols;

    // Sequencer
    logic [1:0]             r_state;
    logic [3:0]             r_col;
    logic                   r_rd_v;
    logic [SIDE_W-1:0]      r_rd_col;
    logic [KEY_W-1:0]       r_pos;
    logic [KEY_W:0]         r_cnt;
    logic [MATRIX_KEYS-1:0] r_next;
    logic [MATRIX_KEYS-1:0] r_chg;

    logic                   accept;
    logic                   load_wr;
    logic [MATRIX_KEYS-1:0] next_map;
    logic [31:0]            status;
    logic [31:0]            entry;
    logic [4:0]             key_count;
    logic [SIDE-1:0]        row_mask;
    logic [SIDE-1:0]        state_q;
    logic [SIDE-1:0]        chg_col;
    logic [3:0]             chg_pop;
    logic                   evt_issue;
    t_evt                   evt;
    logic                   can_issue;
    logic [KEYCODE_WIDTH-1:0] code_q;
    logic [KEY_CODE_W-1:0]  code_ext;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign status        = s_axis_tdata[31:0];
    assign entry         = s_axis_tdata[191:160];
    assign key_count     = status[30:26];

    // Configuration registers, counts above 8 clamp to 8
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 4'd8;
            r_cols <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default:  r_rows <= r_rows;
            endcase
        end
    end

    assign nrows = (r_rows > 4'd8) ? 4'd8 : r_rows;
    assign ncols = (r_cols > 4'd8) ? 4'd8 : r_cols;

    always_comb begin
        for (int r = 0; r < SIDE; r++) begin
            row_mask[r] = (4'(r) < nrows);
        end
    end

    // Build the new pressed map, flat index col*8 + row
    always_comb begin
        next_map = '0;
        if (key_count == 5'd1) begin
            if ((status[3:0] < ncols) && (status[7:4] < nrows)) begin
                next_map[{status[2:0], status[6:4]}] = 1'b1;
            end
        end else if (key_count > 5'd1) begin
            for (int c = 0; c < SIDE; c++) begin
                next_map[c*SIDE +: SIDE] = s_axis_tdata[32 + (c/2)*32 + (c%2)*16 +: SIDE];
            end
        end
    end

    // Keycode load: ignore entries outside the matrix
    assign load_wr = accept && (s_axis_tuser == ACT_LOAD) && !entry[31] && !entry[27];

    // Compare one stored column with the new map
    always_comb begin
        chg_col = (state_q ^ r_next[{r_rd_col, 3'b000} +: SIDE]) & row_mask;
        if ({1'b0, r_rd_col} >= ncols) begin
            chg_col = '0;
        end
        chg_pop = '0;
        for (int r = 0; r < SIDE; r++) begin
            chg_pop = chg_pop + {3'b000, chg_col[r]};
        end
    end

    // Event issue during the walk
    assign evt_issue   = (r_state == S_EVT) && (r_cnt != '0) && r_chg[r_pos] && can_issue;
    assign evt.pressed = r_next[r_pos];
    assign evt.row     = r_pos[2:0];
    assign evt.col     = r_pos[5:3];
    assign evt.last    = (r_cnt == 7'd1);

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_v  <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_COLS) && !r_col[3];
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (s_axis_tuser == ACT_SCAN)) begin
                        r_state <= S_COLS;
                    end
                end
                S_COLS: begin
                    if (r_col[3]) begin
                        r_state <= S_EVT;
                    end
                end
                S_EVT: begin
                    if (r_cnt == '0) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        r_rd_col <= r_col[2:0];
        if (accept) begin
            r_next <= next_map;
            r_col  <= '0;
            r_cnt  <= '0;
            r_pos  <= '0;
        end else begin
            if ((r_state == S_COLS) && !r_col[3]) begin
                r_col <= r_col + 4'd1;
            end
            if (r_rd_v) begin
                r_chg[{r_rd_col, 3'b000} +: SIDE] <= chg_col;
                r_cnt <= r_cnt + {3'b000, chg_pop};
            end
            if ((r_state == S_EVT) && (r_cnt != '0)) begin
                if (!r_chg[r_pos]) begin
                    r_pos <= r_pos + 6'd1;
                end else if (can_issue) begin
                    r_pos <= r_pos + 6'd1;
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    // Stored pressed map, one row mask per column
    mkcr_vmem #(
        .W (SIDE),
        .A (SIDE_W)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   ((r_state == S_COLS) && !r_col[3]),
        .i_rd_addr (r_col[2:0]),
        .o_rd_data (state_q),
        .i_wr_en   (r_rd_v),
        .i_wr_addr (r_rd_col),
        .i_wr_data (r_next[{r_rd_col, 3'b000} +: SIDE])
    );

    // Keycode table, address row*8 + column
    mkcr_vmem #(
        .W (KEYCODE_WIDTH),
        .A (KEY_W)
    ) u_code_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (evt_issue),
        .i_rd_addr ({r_pos[2:0], r_pos[5:3]}),
        .o_rd_data (code_q),
        .i_wr_en   (load_wr),
        .i_wr_addr ({entry[30:28], entry[26:24]}),
        .i_wr_data (entry[KEYCODE_WIDTH-1:0])
    );

    always_comb begin
        code_ext                      = '0;
        code_ext[KEYCODE_WIDTH-1:0]   = code_q;
    end

    mkcr_evt_out u_evt_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue_v     (evt_issue),
        .i_issue       (evt),
        .i_code        (code_ext),
        .o_can_issue   (can_issue),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Checks
    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EVT) && (r_cnt == '0)) |=> (r_state == S_IDLE))
        else $error("walk did not end after the final event");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (evt_issue && evt.last) |=> (r_cnt == '0))
        else $error("events remain after the last one was issued");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the matrix key change reporter.
`timescale 1ns / 1ps

module tb;
    import mkcr_pkg::*;

    localparam int LIMIT       = 1000000;
    localparam int PAUSE       = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 9;
    localparam int PER_PHASE   = 45;

    // One input beat: action on tuser, the rest packed into tdata
    typedef struct packed {
        logic             act;
        logic [31:0]      entry;
        logic [3:0][31:0] mw;
        logic [31:0]      status;
    } key_item_t;

    // One change event as it leaves the block
    typedef struct packed {
        logic [23:0] code;
        logic        pressed;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
    } key_event_t;

    // Directed row: typed expectation where obvious, else -1 for the predictor
    typedef struct {
        key_item_t  it;
        int         n_typed;
        key_event_t t0;
        key_event_t t1;
    } dir_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_index = 1'b0;
    logic [3:0]             i_cfg_data = 4'd0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // Predictor state: one row mask per column, keycode table, register copies
    logic [7:0]  pressed_map [8];
    logic [23:0] keycode_mem [64];
    logic [3:0]  rows_reg;
    logic [3:0]  cols_reg;

    key_event_t       pending_events[$];
    dir_row_t         dir_rows[$];
    logic [3:0][31:0] last_words;
    int               idle_mode = 0;
    int               mismatches = 0;
    int               cycles = 0;
    bit               hold_start = 1'b0;
    bit               hold_over = 1'b0;

    matrix_key_change_reporter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Long receiver hold-off so the block backs up into its input
    initial begin
        wait (hold_start);
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_over = 1'b1;
    end

    // Receiver: stall during the hold-off, else at random according to the idle mode
    always @(negedge i_clk) begin
        if (hold_start && !hold_over)
            m_axis_tready <= 1'b0;
        else if (idle_mode == 0)
            m_axis_tready <= ($urandom_range(0, 99) >= 77);
        else if (idle_mode == 1)
            m_axis_tready <= ($urandom_range(0, 99) >= 19);
        else
            m_axis_tready <= 1'b1;
    end

    // Compare each output beat with the oldest expected event
    always @(posedge i_clk) begin : event_check
        key_event_t seen;
        key_event_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = '{m_axis_tdata[23:0], m_axis_tdata[24], m_axis_tdata[27:25],
                     m_axis_tdata[30:28], m_axis_tlast};
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected key event: got %h", seen);
            end else begin
                want = pending_events.pop_front();
                if (seen !== want || m_axis_tdata[31] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("key event mismatch: exp %h got %h (tdata %h)",
                                 want, seen, m_axis_tdata);
                end
            end
        end
    end

    // Advance the key model by one accepted beat; queue its events if asked
    task automatic track_beat(input key_item_t it, input bit queue_events);
        logic [7:0] next_map [8];
        logic [4:0] count;
        logic [3:0] kr;
        logic [3:0] kc;
        int         nr;
        int         nc;
        bit         have_prev;
        key_event_t prev;
        if (it.act == ACT_LOAD) begin
            kr = it.entry[31:28];
            kc = it.entry[27:24];
            if (kr < 8 && kc < 8)
                keycode_mem[{kr[2:0], kc[2:0]}] = it.entry[23:0];
            return;
        end
        count = it.status[30:26];
        nr = (rows_reg > 8) ? 8 : rows_reg;
        nc = (cols_reg > 8) ? 8 : cols_reg;
        for (int c = 0; c < 8; c++)
            next_map[c] = 8'd0;
        if (count == 5'd1) begin
            kc = it.status[3:0];
            kr = it.status[7:4];
            if (kc < nc && kr < nr)
                next_map[kc] = 8'd1 << kr;
        end else if (count > 5'd1) begin
            for (int c = 0; c < 8; c++)
                next_map[c] = c[0] ? it.mw[c >> 1][23:16] : it.mw[c >> 1][7:0];
        end
        // Hold back each event until the next one shows it was not the last
        have_prev = 1'b0;
        for (int c = 0; c < nc; c++) begin
            for (int r = 0; r < nr; r++) begin
                if (pressed_map[c][r] != next_map[c][r]) begin
                    if (have_prev && queue_events)
                        pending_events.push_back(prev);
                    prev = '{keycode_mem[r * 8 + c], next_map[c][r], r[2:0], c[2:0], 1'b0};
                    have_prev = 1'b1;
                end
            end
        end
        if (have_prev && queue_events) begin
            prev.last = 1'b1;
            pending_events.push_back(prev);
        end
        for (int c = 0; c < 8; c++)
            pressed_map[c] = next_map[c];
    endtask

    // Offer one beat, idling first at the sender's rate, and wait for it to go in
    task automatic send_beat(input key_item_t it, input int n_typed,
                             input key_event_t t0, input key_event_t t1);
        int idle_pct;
        idle_pct = (idle_mode == 0) ? 19 : (idle_mode == 1) ? 77 : 0;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(9, 80)) @(negedge i_clk);
            else
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.act;
        s_axis_tdata  <= {it.entry, it.mw, it.status};
        do @(posedge i_clk); while (!s_axis_tready);
        track_beat(it, n_typed < 0);
        if (n_typed > 0)
            pending_events.push_back(t0);
        if (n_typed > 1)
            pending_events.push_back(t1);
    endtask

    // Let every expected event drain, then give the block time to finish its walk
    task automatic drain_and_pause();
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (PAUSE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ROWS)
            rows_reg = val;
        else
            cols_reg = val;
    endtask

    // Mostly in-range position, now and then beyond the matrix
    function automatic logic [3:0] pick_pos();
        return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(8, 15))
                                           : 4'($urandom_range(0, 7));
    endfunction

    // Random beat: loads, and scans of every key count with evolving maps
    function automatic key_item_t random_beat();
        key_item_t it;
        int        pick;
        int        bit_idx;
        it.act    = ACT_SCAN;
        it.status = $urandom;
        it.entry  = $urandom;
        for (int k = 0; k < 4; k++)
            it.mw[k] = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            it.act = ACT_LOAD;
            it.entry[31:28] = pick_pos();
            it.entry[27:24] = pick_pos();
        end else if (pick < 37) begin
            it.status[30:26] = 5'd0;
        end else if (pick < 55) begin
            it.status[30:26] = 5'd1;
            it.status[7:4]   = pick_pos();
            it.status[3:0]   = pick_pos();
        end else begin
            it.status[30:26] = 5'($urandom_range(2, 31));
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                // Small change to the previous map
                it.mw = last_words;
                repeat ($urandom_range(0, 3)) begin
                    bit_idx = $urandom_range(0, 127);
                    it.mw[bit_idx / 32][bit_idx % 32] = ~it.mw[bit_idx / 32][bit_idx % 32];
                end
            end else if (pick < 8) begin
                for (int k = 0; k < 4; k++)
                    it.mw[k] = $urandom & $urandom & $urandom;
            end
            last_words = it.mw;
        end
        return it;
    endfunction

    task automatic add_row(input logic act, input logic [31:0] status, input logic [31:0] w,
                           input logic [31:0] entry, input int n,
                           input key_event_t t0, input key_event_t t1);
        dir_row_t row;
        row.it.act    = act;
        row.it.status = status;
        row.it.mw     = {w, w, w, w};
        row.it.entry  = entry;
        row.n_typed   = n;
        row.t0        = t0;
        row.t1        = t1;
        dir_rows.push_back(row);
    endtask

    initial begin
        logic [3:0] rows_list [PHASES];
        logic [3:0] cols_list [PHASES];
        key_event_t none;
        none = '0;
        rows_list = '{4'd8, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd1, 4'($urandom_range(0, 15))};
        cols_list = '{4'd8, 4'd8, 4'd1, 4'd5, 4'd15, 4'd6, 4'd0, 4'd1, 4'($urandom_range(0, 15))};
        for (int c = 0; c < 8; c++)
            pressed_map[c] = 8'd0;
        for (int k = 0; k < 64; k++)
            keycode_mem[k] = 24'd0;
        rows_reg   = 4'd8;
        cols_reg   = 4'd8;
        last_words = '0;

        // Directed table: reset state, table loads, key counts of zero, one and more, edges
        add_row(ACT_SCAN, 32'h0000_0000, 32'h0, 32'h0, 0, none, none);
        add_row(ACT_SCAN, 32'h0400_0000, 32'h0, 32'h0, 1,
                '{24'h0, 1'b1, 3'd0, 3'd0, 1'b1}, none);
        add_row(ACT_LOAD, 32'h0, 32'h0, 32'h00FF_FFFF, 0, none, none);
        add_row(ACT_LOAD, 32'h0, 32'h0, 32'h77AB_CDEF, 0, none, none);
        add_row(ACT_LOAD, 32'h0, 32'h0, 32'h8012_3456, 0, none, none);
        add_row(ACT_LOAD, 32'h0, 32'h0, 32'h0F65_4321, 0, none, none);
        add_row(ACT_SCAN, 32'h0400_0077, 32'h0, 32'h0, 2,
                '{24'hFF_FFFF, 1'b0, 3'd0, 3'd0, 1'b0},
                '{24'hAB_CDEF, 1'b1, 3'd7, 3'd7, 1'b1});
        add_row(ACT_SCAN, 32'h0400_0080, 32'h0, 32'h0, 1,
                '{24'hAB_CDEF, 1'b0, 3'd7, 3'd7, 1'b1}, none);
        add_row(ACT_SCAN, 32'h0800_0000, 32'hFFFF_FFFF, 32'h0, -1, none, none);
        add_row(ACT_SCAN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none, none);
        add_row(ACT_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none, none);
        add_row(ACT_SCAN, 32'h83FF_FFFF, 32'hFFFF_FFFF, 32'h0, -1, none, none);
        add_row(ACT_LOAD, 32'h0, 32'h0, 32'h5300_0001, 0, none, none);
        add_row(ACT_SCAN, 32'h85FF_FF53, 32'h0, 32'hFFFF_FFFF, 1,
                '{24'h00_0001, 1'b1, 3'd5, 3'd3, 1'b1}, none);
        add_row(ACT_SCAN, 32'h0800_0000, 32'h5A5A_A5A5, 32'h1234_5678, -1, none, none);
        add_row(ACT_SCAN, 32'h0400_00FF, 32'h0, 32'h0, -1, none, none);
        add_row(ACT_SCAN, 32'h0400_0008, 32'h0, 32'h0, 0, none, none);
        add_row(ACT_SCAN, 32'h0400_0070, 32'h0, 32'h0, 1,
                '{24'h0, 1'b1, 3'd7, 3'd0, 1'b1}, none);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_beat(dir_rows[i].it, dir_rows[i].n_typed, dir_rows[i].t0, dir_rows[i].t1);

        // Random phases: three idle modes, several register settings each
        for (int ph = 0; ph < PHASES; ph++) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            drain_and_pause();
            idle_mode = ph / 3;
            write_reg(CFG_ROWS, rows_list[ph]);
            write_reg(CFG_COLS, cols_list[ph]);
            if (ph == 3)
                hold_start = 1'b1;
            repeat (PER_PHASE)
                send_beat(random_beat(), -1, none, none);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // Wait out the tail
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (PAUSE) @(posedge i_clk);

        if (mismatches == 0 && pending_events.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
